// File: hw/rtl/lifc_pkg.sv
// Shared constants, types and register codes for the LIF convolution timestep unit.
package lifc_pkg;

  localparam int IN_SIZE    = 5;
  localparam int OUT_SIZE   = IN_SIZE - 1;
  localparam int IN_BITS    = 25;
  localparam int OUT_BITS   = 16;
  localparam int NEURON_CAP = 16;
  localparam int LANES      = (OUT_SIZE * OUT_SIZE < NEURON_CAP) ?
                              OUT_SIZE * OUT_SIZE : NEURON_CAP;
  localparam int TAPS       = 4;

  localparam int MEM_W      = 16;
  localparam int THRESH_W   = 16;
  localparam int WEIGHT_W   = 16;
  localparam int DECAY_W    = 9;
  localparam int DECAY_SH   = 8;
  localparam int PROD_W     = MEM_W + DECAY_W;
  localparam int SUM_W      = WEIGHT_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3       = 3'd5;

  localparam logic [THRESH_W-1:0] RST_THRESHOLD = 16'd60;
  localparam logic [DECAY_W-1:0]  RST_DECAY     = 9'd243;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_0  = 16'd60;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_1  = 16'd120;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_2  = 16'd180;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT_3  = 16'd240;

  typedef struct packed {
    logic [THRESH_W-1:0]             threshold;
    logic [DECAY_W-1:0]              decay;
    logic [TAPS-1:0][WEIGHT_W-1:0]   weight;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture window sum for a newly accepted beat
    logic step;   // advance neuron state, stage 1 beat moves to output
  } lane_ctrl_t;

endpackage

// File: hw/rtl/lifc_ifs.sv
// Handshake channel interfaces: spike input, spike output, register writes.
interface lifc_in_if import lifc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] in_spikes;
  modport source (output valid, output in_spikes, input ready);
  modport sink   (input valid, input in_spikes, output ready);
endinterface

interface lifc_out_if import lifc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] out_spikes;
  modport source (output valid, output out_spikes, input ready);
  modport sink   (input valid, input out_spikes, output ready);
endinterface

interface lifc_cfg_if import lifc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/lif_conv_layer_timestep_unit.sv
// Top level: LIF 2x2 convolution layer, one spike frame per beat.
//
//  channel  | dir | fields                 | notes
//  in_ch    | in  | in_spikes[24:0]        | one frame per beat
//  out_ch   | out | out_spikes[15:0]       | one result per input beat
//  cfg      | in  | index[2:0], data[15:0] | always ready
//
// One frame per cycle sustained while the output is not stalled; the window sum is registered, then the lane update.
// The per-lane decay-multiply, integrate and compare loop sets the cycle.
// Synchronous reset clears membranes, pending flags and both valid bits.
// Output stalls hold the result register; input stays ready while stage 1 can drain.
module lif_conv_layer_timestep_unit import lifc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lifc_in_if.sink    in_ch,
  lifc_out_if.source out_ch,
  lifc_cfg_if.sink   cfg
);

  localparam logic [OUT_BITS-1:0] LANE_MASK = OUT_BITS'((33'd1 << LANES) - 33'd1);

  cfg_t                regs;
  lane_ctrl_t          ctrl;
  logic                s1_valid;
  logic                out_valid;
  logic                out_free;
  logic                in_beat;
  logic [LANES-1:0]    lane_fire;
  logic [OUT_BITS-1:0] out_spikes;

  lifc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign out_free     = !out_valid || out_ch.ready;
  assign in_ch.ready  = !s1_valid || out_free;
  assign in_beat      = in_ch.valid && in_ch.ready;
  assign ctrl.load    = in_beat;
  assign ctrl.step    = s1_valid && out_free;

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    localparam int R = n / OUT_SIZE;
    localparam int C = n % OUT_SIZE;
    logic [TAPS-1:0] taps;

    for (genvar k = 0; k < TAPS; k++) begin : g_tap
      localparam int IDX = (R + k / 2) * IN_SIZE + C + k % 2;
      if (IDX < IN_BITS) begin : g_in
        assign taps[k] = in_ch.in_spikes[IDX];
      end else begin : g_off
        assign taps[k] = 1'b0;
      end
    end

    lifc_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .regs (regs),
      .taps (taps),
      .fire (lane_fire[n])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_beat;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      out_spikes <= OUT_BITS'(lane_fire);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_spikes = out_spikes;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !out_ch.valid)
    else $error("result valid straight after reset");

  // neurons past the kept set never spike
  a_lane_mask: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.out_spikes & ~LANE_MASK) == '0))
    else $error("spike on a neuron that is not kept");

  // an accepted frame always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> s1_valid)
    else $error("accepted beat lost before stage 1");

  // a stage 1 beat that cannot move stays put
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && out_valid))
    else $error("stage 1 beat dropped under stall");

endmodule

// File: hw/rtl/lifc_cfg.sv
// Configuration register file: threshold, decay and kernel weights.
module lifc_cfg import lifc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  lifc_cfg_if.sink cfg,
  output cfg_t     regs
);

  cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_FIRE_THRESHOLD: regs_next.threshold = cfg.data;
        REG_DECAY_FACTOR:   regs_next.decay     = cfg.data[DECAY_W-1:0];
        REG_WEIGHT_0:       regs_next.weight[0] = cfg.data;
        REG_WEIGHT_1:       regs_next.weight[1] = cfg.data;
        REG_WEIGHT_2:       regs_next.weight[2] = cfg.data;
        REG_WEIGHT_3:       regs_next.weight[3] = cfg.data;
        default:            regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold <= RST_THRESHOLD;
      regs.decay     <= RST_DECAY;
      regs.weight[0] <= RST_WEIGHT_0;
      regs.weight[1] <= RST_WEIGHT_1;
      regs.weight[2] <= RST_WEIGHT_2;
      regs.weight[3] <= RST_WEIGHT_3;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

// File: hw/rtl/lifc_lane.sv
// One neuron lane: window weight sum, then decay, integrate, soft reset and fire.
module lifc_lane import lifc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  lane_ctrl_t      ctrl,
  input  cfg_t            regs,
  input  logic [TAPS-1:0] taps,
  output logic            fire
);

  logic [SUM_W-1:0]    sum;
  logic [WEIGHT_W-1:0] win_sum_next;
  logic [WEIGHT_W-1:0] win_sum;

  logic [MEM_W-1:0]    membrane;
  logic                pending;
  logic [PROD_W-1:0]   prod;
  logic [MEM_W:0]      decayed_wide;
  logic [MEM_W-1:0]    decayed;
  logic [MEM_W:0]      acc_wide;
  logic [MEM_W-1:0]    acc;
  logic [MEM_W-1:0]    membrane_next;

  // stage 1: sum of weights of spiking window pixels, saturated
  always_comb begin
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      if (taps[k]) begin
        sum = sum + SUM_W'(regs.weight[k]);
      end
    end
    win_sum_next = (|sum[SUM_W-1:WEIGHT_W]) ? '1 : sum[WEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      win_sum <= win_sum_next;
    end
  end

  // stage 2: state update
  always_comb begin
    prod          = PROD_W'(membrane) * PROD_W'(regs.decay);
    decayed_wide  = prod[DECAY_SH +: MEM_W + 1];
    decayed       = decayed_wide[MEM_W] ? '1 : decayed_wide[MEM_W-1:0];
    acc_wide      = {1'b0, decayed} + {1'b0, win_sum};
    acc           = acc_wide[MEM_W] ? '1 : acc_wide[MEM_W-1:0];
    membrane_next = acc;
    if (pending) begin
      membrane_next = (acc >= regs.threshold) ? acc - regs.threshold : '0;
    end
    fire = (membrane_next >= regs.threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane <= '0;
      pending  <= 1'b0;
    end else if (ctrl.step) begin
      membrane <= membrane_next;
      pending  <= fire;
    end
  end

endmodule
